// ===== rtl/sirc_pkg.sv =====
// Shared types, constants and helpers for the signed integer to radix digit converter.
// Used by sirc_div and the top level; depends on nothing.
package sirc_pkg;

  // Field widths
  localparam int SYMBOL_W   = 8;
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int TABLE_SIZE = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Quotient bits produced per divider cycle
  localparam int DIV_STEP_BITS = 4;

  // Character codes and table limits
  localparam logic [SYMBOL_W-1:0] MINUS_CODE     = 8'd45;
  localparam logic [SYMBOL_W-1:0] PLUS_CODE      = 8'd43;
  localparam logic [SYMBOL_W-1:0] LOW_PRINTABLE  = 8'd32;
  localparam logic [SYMBOL_W-1:0] HIGH_PRINTABLE = 8'd126;
  localparam logic [RADIX_W-1:0]  MIN_SYMBOLS    = 5'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Reset contents: decimal digits then lowercase hex letters
  localparam logic [RADIX_W-1:0]    RESET_SYMBOL_COUNT = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RESET_SYMBOLS_LOW  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] RESET_SYMBOLS_HIGH = 64'h6665646362613938;

  // Look up the character code of a digit in the two table words
  function automatic logic [SYMBOL_W-1:0] symbol_code(
    input logic [CFG_DATA_W-1:0] lo,
    input logic [CFG_DATA_W-1:0] hi,
    input logic [DIGIT_W-1:0]    digit
  );
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{digit, 3'b000} +: SYMBOL_W];
  endfunction

endpackage

// ===== rtl/sirc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sirc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sirc_div.sv =====
// Iterative divider: unsigned value by a radix of up to 16, four quotient bits per cycle.
// Depends on sirc_pkg.
module sirc_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [sirc_pkg::RADIX_W-1:0]   divisor,
  output logic                           done,
  output logic [VALUE_BITS-1:0]          quotient,
  output logic [sirc_pkg::DIGIT_W-1:0]   remainder
);

  localparam int STEP   = sirc_pkg::DIV_STEP_BITS;
  localparam int DIV_W  = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int ROUNDS = DIV_W / STEP;
  localparam int RCW    = $clog2(ROUNDS + 1);

  logic                          running;
  logic [RCW-1:0]                rounds_left;
  logic [sirc_pkg::RADIX_W-1:0]  div_reg;
  logic [sirc_pkg::DIGIT_W-1:0]  rem;
  logic [sirc_pkg::DIGIT_W-1:0]  rem_next;
  logic [DIV_W-1:0]              quo;
  logic [DIV_W-1:0]              quo_next;
  logic [sirc_pkg::RADIX_W-1:0]  trial;

  // One round: STEP restoring steps, dividend shifts out the top, quotient in the bottom
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int s = 0; s < STEP; s++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= div_reg) begin
        trial       = trial - div_reg;
        quo_next[0] = 1'b1;
      end
      rem_next = trial[sirc_pkg::DIGIT_W-1:0];
    end
  end

  // Round counter and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      done        <= 1'b0;
      rounds_left <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running     <= 1'b1;
        rounds_left <= RCW'(ROUNDS);
        div_reg     <= divisor;
        rem         <= '0;
        quo         <= DIV_W'(dividend);
      end else if (running) begin
        rem         <= rem_next;
        quo         <= quo_next;
        rounds_left <= rounds_left - 1'b1;
        if (rounds_left == RCW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

// ===== rtl/signed_int_to_custom_radix_digits.sv =====
// Top level: signed integer to symbol string in a configurable radix.
// Depends on sirc_pkg, sirc_div and sirc_ram.
//
// A value is taken when start is high, busy is low and symbol_count lies in
// 2..MAX_SYMBOLS; with any other count start is ignored. The block first checks the
// symbol table, one entry a cycle; a bad table ends the item with no output. It then
// divides by the radix once per digit on the shared divider, storing digits in a
// small RAM. Output then follows: an optional '-' and then the digits, most
// significant first, one symbol per cycle on strobe, with last on the final one.
// The receiver cannot stall, so strobe is a transfer. busy stays high until the last
// symbol is driven; configuration writes are always taken and must be made only
// while busy is low.
module signed_int_to_custom_radix_digits #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                value,
  output logic                              strobe,
  output logic [sirc_pkg::SYMBOL_W-1:0]     symbol,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sirc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sirc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PRIME,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [sirc_pkg::RADIX_W-1:0]    symbol_count;
  logic [sirc_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [sirc_pkg::CFG_DATA_W-1:0] symbols_high;

  // Working registers
  logic                            neg;
  logic [VALUE_BITS-1:0]           remaining_quotient;
  logic [CW-1:0]                   digit_count;
  logic [AW-1:0]                   rd_idx;
  logic [sirc_pkg::DIGIT_W-1:0]    chk_idx;

  logic [VALUE_BITS-1:0]           raw;
  logic [VALUE_BITS-1:0]           mag;
  logic                            count_ok;
  logic [sirc_pkg::SYMBOL_W-1:0]   chk_code;
  logic                            chk_bad;

  logic                            div_go;
  logic                            div_done;
  logic [VALUE_BITS-1:0]           div_quo;
  logic [sirc_pkg::DIGIT_W-1:0]    div_rem;

  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  logic [sirc_pkg::DIGIT_W-1:0]    ram_rdata;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= sirc_pkg::RESET_SYMBOL_COUNT;
      symbols_low  <= sirc_pkg::RESET_SYMBOLS_LOW;
      symbols_high <= sirc_pkg::RESET_SYMBOLS_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sirc_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_data[sirc_pkg::RADIX_W-1:0];
        sirc_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        sirc_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Magnitude of the input; the most negative value wraps to its own magnitude
  assign raw      = value[VALUE_BITS-1:0];
  assign mag      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign count_ok = (symbol_count >= sirc_pkg::MIN_SYMBOLS) &&
                    (symbol_count <= sirc_pkg::RADIX_W'(MAX_SYMBOLS));

  // Table check for one entry: printable, not a sign, no earlier duplicate
  always_comb begin
    chk_code = sirc_pkg::symbol_code(symbols_low, symbols_high, chk_idx);
    chk_bad  = (chk_code < sirc_pkg::LOW_PRINTABLE) ||
               (chk_code > sirc_pkg::HIGH_PRINTABLE) ||
               (chk_code == sirc_pkg::MINUS_CODE) ||
               (chk_code == sirc_pkg::PLUS_CODE);
    for (int j = 0; j < sirc_pkg::TABLE_SIZE; j++) begin
      if ((sirc_pkg::DIGIT_W'(j) < chk_idx) &&
          (sirc_pkg::symbol_code(symbols_low, symbols_high, sirc_pkg::DIGIT_W'(j)) ==
           chk_code)) begin
        chk_bad = 1'b1;
      end
    end
  end

  // Shared divider
  assign div_go = (state == S_DIV_GO);

  sirc_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (remaining_quotient),
    .divisor   (symbol_count),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Digit store: written least significant first, read back in reverse
  assign ram_we    = (state == S_DIV_WAIT) && div_done;
  assign ram_raddr = (state == S_EMIT) ? (rd_idx - 1'b1) : rd_idx;

  sirc_ram #(
    .WIDTH (sirc_pkg::DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[AW-1:0]),
    .wdata (div_rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      strobe             <= 1'b0;
      last               <= 1'b0;
      symbol             <= '0;
      neg                <= 1'b0;
      remaining_quotient <= '0;
      digit_count        <= '0;
      rd_idx             <= '0;
      chk_idx            <= '0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && count_ok) begin
            neg                <= raw[VALUE_BITS-1];
            remaining_quotient <= mag;
            chk_idx            <= '0;
            state              <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (chk_bad) begin
            state <= S_IDLE;
          end else if ({1'b0, chk_idx} == (symbol_count - 1'b1)) begin
            digit_count <= '0;
            state       <= S_DIV_GO;
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            digit_count        <= digit_count + 1'b1;
            remaining_quotient <= div_quo;
            if (div_quo == '0) begin
              rd_idx <= digit_count[AW-1:0];
              state  <= S_PRIME;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        S_PRIME: begin
          // First digit read is in flight; send the sign meanwhile
          if (neg) begin
            strobe <= 1'b1;
            symbol <= sirc_pkg::MINUS_CODE;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          symbol <= sirc_pkg::symbol_code(symbols_low, symbols_high, ram_rdata);
          last   <= (rd_idx == '0);
          if (rd_idx == '0) begin
            state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/signed_int_to_custom_radix_digits_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_custom_radix_digits: directed and random
// values under changing symbol tables. Depends on sirc_pkg and the RTL top level.
module signed_int_to_custom_radix_digits_test;

  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [sirc_pkg::SYMBOL_W-1:0] code;
    logic                          last;
  } symbol_entry_t;

  // Ways a random table gets broken
  typedef enum int {BAD_FEW, BAD_MANY, BAD_RANGE, BAD_SIGN, BAD_REPEAT} table_fault_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            start     = 1'b0;
  logic signed [31:0]              value     = '0;
  logic                            cfg_valid = 1'b0;
  logic [sirc_pkg::CFG_IDX_W-1:0]  cfg_index = sirc_pkg::REG_SYMBOL_COUNT;
  logic [sirc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            busy;
  logic                            strobe;
  logic [sirc_pkg::SYMBOL_W-1:0]   symbol;
  logic                            last;
  logic                            cfg_ready;

  // Shadow copy of the configuration registers
  logic [sirc_pkg::RADIX_W-1:0]    radix_setting = sirc_pkg::RESET_SYMBOL_COUNT;
  logic [sirc_pkg::CFG_DATA_W-1:0] table_lo      = sirc_pkg::RESET_SYMBOLS_LOW;
  logic [sirc_pkg::CFG_DATA_W-1:0] table_hi      = sirc_pkg::RESET_SYMBOLS_HIGH;

  symbol_entry_t pending_symbols[$];
  symbol_entry_t head;
  int error_count     = 0;
  int values_sent     = 0;
  int values_ignored  = 0;
  int symbols_checked = 0;
  int tables_loaded   = 0;
  int idle_pct        = 32;

  logic signed [31:0] corner_values [5] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1,
                                            32'sd1};

  always #4 clk = ~clk;

  signed_int_to_custom_radix_digits u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .symbol    (symbol),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Character code of one digit under the current table
  function automatic logic [sirc_pkg::SYMBOL_W-1:0] digit_code(input int d);
    if (d < 8) return table_lo[8*d +: 8];
    return table_hi[8*(d-8) +: 8];
  endfunction

  // Table must have 2..16 distinct printable symbols, none of them a sign
  function automatic bit table_valid();
    logic [sirc_pkg::SYMBOL_W-1:0] c;
    if (radix_setting < sirc_pkg::MIN_SYMBOLS || radix_setting > sirc_pkg::TABLE_SIZE)
      return 1'b0;
    for (int i = 0; i < radix_setting; i++) begin
      c = digit_code(i);
      if (c < sirc_pkg::LOW_PRINTABLE || c > sirc_pkg::HIGH_PRINTABLE) return 1'b0;
      if (c == sirc_pkg::PLUS_CODE || c == sirc_pkg::MINUS_CODE) return 1'b0;
      for (int j = 0; j < i; j++)
        if (digit_code(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the symbol stream one accepted value should produce
  function automatic void predict_symbols(input logic signed [31:0] v);
    logic [31:0] quotient;
    logic [3:0]  digits[$];
    logic [3:0]  d;
    int          radix;
    if (!table_valid()) begin
      values_ignored++;
      return;
    end
    radix = radix_setting;
    // Two's complement negate also yields the full magnitude of the most negative value
    quotient = v[31] ? (~v + 32'd1) : v;
    do begin
      digits.push_back(4'(quotient % radix));
      quotient = quotient / radix;
    end while (quotient != 0);
    if (v[31]) pending_symbols.push_back(symbol_entry_t'{sirc_pkg::MINUS_CODE, 1'b0});
    while (digits.size() > 0) begin
      d = digits.pop_back();
      pending_symbols.push_back(symbol_entry_t'{digit_code(d), digits.size() == 0});
    end
  endfunction

  // Compare every strobed symbol with the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe !== 1'b0) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %02h last %b", symbol, last));
      end else begin
        head = pending_symbols.pop_front();
        symbols_checked++;
        if (symbol !== head.code)
          report_mismatch($sformatf("symbol %02h, expected %02h", symbol, head.code));
        if (last !== head.last)
          report_mismatch($sformatf("last %b, expected %b", last, head.last));
      end
    end
  end

  // Send one value; start may stay high into the next call
  task automatic send_value(input logic signed [31:0] v);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(4, 300) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    values_sent++;
    predict_symbols(v);
  endtask

  // Drop start, let every expected symbol arrive, then let the block settle
  task automatic wait_idle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_symbols.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_symbols.size() != 0) begin
      report_mismatch($sformatf("%0d expected symbols never arrived", pending_symbols.size()));
      pending_symbols.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Register write; valid is left high for back-to-back transfers
  task automatic write_register(input logic [sirc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sirc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      sirc_pkg::REG_SYMBOL_COUNT: radix_setting = data[sirc_pkg::RADIX_W-1:0];
      sirc_pkg::REG_SYMBOLS_LOW:  table_lo = data;
      default:                    table_hi = data;
    endcase
  endtask

  // Load all three registers once the block is idle
  task automatic load_table(input logic [sirc_pkg::RADIX_W-1:0] count,
                            input logic [sirc_pkg::CFG_DATA_W-1:0] lo,
                            input logic [sirc_pkg::CFG_DATA_W-1:0] hi);
    logic [sirc_pkg::CFG_DATA_W-1:0] count_word;
    wait_idle();
    // Upper bits of the count word are don't-care; fill them with noise
    count_word = {$urandom, $urandom};
    count_word[sirc_pkg::RADIX_W-1:0] = count;
    write_register(sirc_pkg::REG_SYMBOL_COUNT, count_word);
    write_register(sirc_pkg::REG_SYMBOLS_LOW, lo);
    write_register(sirc_pkg::REG_SYMBOLS_HIGH, hi);
    cfg_valid <= 1'b0;
    tables_loaded++;
  endtask

  function automatic logic [sirc_pkg::CFG_DATA_W-1:0] with_byte(
    input logic [sirc_pkg::CFG_DATA_W-1:0] word,
    input int pos,
    input logic [sirc_pkg::SYMBOL_W-1:0] code
  );
    word[8*pos +: 8] = code;
    return word;
  endfunction

  // Random table of distinct legal symbols, optionally broken in one way
  function automatic void build_table(input int forced_count, input bit broken,
                                      output logic [sirc_pkg::RADIX_W-1:0] count,
                                      output logic [2*sirc_pkg::CFG_DATA_W-1:0] codes);
    logic [sirc_pkg::SYMBOL_W-1:0] pool[$];
    logic [sirc_pkg::SYMBOL_W-1:0] tmp;
    int k;
    int victim;
    for (int c = sirc_pkg::LOW_PRINTABLE; c <= sirc_pkg::HIGH_PRINTABLE; c++)
      if (c != sirc_pkg::PLUS_CODE && c != sirc_pkg::MINUS_CODE) pool.push_back(8'(c));
    codes = {$urandom, $urandom, $urandom, $urandom};
    count = (forced_count != 0) ? sirc_pkg::RADIX_W'(forced_count)
                                : sirc_pkg::RADIX_W'($urandom_range(2, 16));
    // Partial shuffle picks the first count symbols
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(i, pool.size() - 1);
      tmp = pool[k];
      pool[k] = pool[i];
      pool[i] = tmp;
      codes[8*i +: 8] = pool[i];
    end
    if (broken) begin
      victim = $urandom_range(0, count - 1);
      case (table_fault_t'($urandom_range(0, 4)))
        BAD_FEW:   count = sirc_pkg::RADIX_W'($urandom_range(0, 1));
        BAD_MANY:  count = sirc_pkg::RADIX_W'($urandom_range(17, 31));
        BAD_RANGE: codes[8*victim +: 8] = $urandom_range(1) ? 8'($urandom_range(0, 31))
                                                            : 8'($urandom_range(127, 255));
        BAD_SIGN:  codes[8*victim +: 8] = $urandom_range(1) ? sirc_pkg::PLUS_CODE
                                                            : sirc_pkg::MINUS_CODE;
        default:   codes[8*(count-1) +: 8] = codes[7:0];
      endcase
    end
  endfunction

  // Mix of full-range, small, radix-boundary and corner values
  function automatic logic signed [31:0] random_value();
    int     pick;
    int     r;
    int     off;
    longint p;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 70) return $urandom_range(1) ? -$urandom_range(0, 40) : $urandom_range(0, 40);
    if (pick < 85) begin
      r = (radix_setting >= sirc_pkg::MIN_SYMBOLS && radix_setting <= sirc_pkg::TABLE_SIZE)
          ? radix_setting : 10;
      p = 1;
      repeat ($urandom_range(1, 31))
        if (p * r <= 64'sh7FFF_FFFF) p = p * r;
      off = $urandom_range(0, 2);
      p = p + off - 1;
      return $urandom_range(1) ? 32'(-p) : 32'(p);
    end
    return corner_values[$urandom_range(0, 4)];
  endfunction

  // Reset table (radix 10): zero, minus one, both extremes and a ten-digit value
  task automatic test_reset_table();
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sd1234567890);
  endtask

  // Smallest and largest radix give the longest and shortest digit strings
  task automatic test_radix_extremes();
    load_table(sirc_pkg::MIN_SYMBOLS, sirc_pkg::RESET_SYMBOLS_LOW,
               sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    load_table(sirc_pkg::RADIX_W'(sirc_pkg::TABLE_SIZE), sirc_pkg::RESET_SYMBOLS_LOW,
               sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sd0);
  endtask

  // Symbols at the printable limits and around the sign codes are legal
  task automatic test_edge_codes();
    logic [sirc_pkg::CFG_DATA_W-1:0] lo;
    lo = {$urandom, $urandom};
    lo = with_byte(lo, 0, sirc_pkg::LOW_PRINTABLE);
    lo = with_byte(lo, 1, sirc_pkg::HIGH_PRINTABLE);
    // Code between plus and minus sits next to both
    lo = with_byte(lo, 2, sirc_pkg::MINUS_CODE - 8'd1);
    lo = with_byte(lo, 3, sirc_pkg::MINUS_CODE + 8'd1);
    lo = with_byte(lo, 4, sirc_pkg::PLUS_CODE - 8'd1);
    load_table(5'd5, lo, {$urandom, $urandom});
    send_value(-32'sd1234567);
    send_value(32'sd7);
  endtask

  // Every way a table is rejected: no symbols may come out
  task automatic test_bad_tables();
    load_table(5'd0, sirc_pkg::RESET_SYMBOLS_LOW, sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(5'd1, sirc_pkg::RESET_SYMBOLS_LOW, sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(5'd17, sirc_pkg::RESET_SYMBOLS_LOW, sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(5'd31, sirc_pkg::RESET_SYMBOLS_LOW, sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(sirc_pkg::RESET_SYMBOL_COUNT,
               with_byte(sirc_pkg::RESET_SYMBOLS_LOW, 0, sirc_pkg::LOW_PRINTABLE - 8'd1),
               sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(sirc_pkg::RESET_SYMBOL_COUNT, sirc_pkg::RESET_SYMBOLS_LOW,
               with_byte(sirc_pkg::RESET_SYMBOLS_HIGH, 1, sirc_pkg::HIGH_PRINTABLE + 8'd1));
    send_value($urandom);
    load_table(sirc_pkg::RESET_SYMBOL_COUNT,
               with_byte(sirc_pkg::RESET_SYMBOLS_LOW, 3, sirc_pkg::PLUS_CODE),
               sirc_pkg::RESET_SYMBOLS_HIGH);
    send_value($urandom);
    load_table(sirc_pkg::RESET_SYMBOL_COUNT, sirc_pkg::RESET_SYMBOLS_LOW,
               with_byte(sirc_pkg::RESET_SYMBOLS_HIGH, 1, sirc_pkg::MINUS_CODE));
    send_value($urandom);
    // Last hex digit repeats digit 0
    load_table(sirc_pkg::RADIX_W'(sirc_pkg::TABLE_SIZE), sirc_pkg::RESET_SYMBOLS_LOW,
               with_byte(sirc_pkg::RESET_SYMBOLS_HIGH, 7, sirc_pkg::RESET_SYMBOLS_LOW[7:0]));
    send_value($urandom);
  endtask

  // Random tables and values over three sender idling profiles
  task automatic test_random();
    logic [sirc_pkg::RADIX_W-1:0]      count;
    logic [2*sirc_pkg::CFG_DATA_W-1:0] codes;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 32 : (phase == 1) ? 56 : 0;
      for (int t = 0; t < 5; t++) begin
        build_table((t == 0) ? 2 : (t == 1) ? sirc_pkg::TABLE_SIZE : 0,
                    t > 1 && $urandom_range(4) == 0, count, codes);
        load_table(count, codes[sirc_pkg::CFG_DATA_W-1:0],
                   codes[2*sirc_pkg::CFG_DATA_W-1:sirc_pkg::CFG_DATA_W]);
        repeat (6) send_value(random_value());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_table();
    test_radix_extremes();
    test_edge_codes();
    test_bad_tables();
    test_random();
    wait_idle();
    $display("Run covered %0d values over %0d table loads (%0d on rejected tables),",
             values_sent, tables_loaded, values_ignored);
    $display("with %0d output symbols compared and %0d mismatches.",
             symbols_checked, error_count);
    if (error_count == 0) begin
      $display("signed_int_to_custom_radix_digits verification clean");
    end else begin
      $display("signed_int_to_custom_radix_digits verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("signed_int_to_custom_radix_digits verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sirc_pkg.sv
rtl/sirc_ram.sv
rtl/sirc_div.sv
rtl/signed_int_to_custom_radix_digits.sv
tb/sv/signed_int_to_custom_radix_digits_test.sv
